FILE: design/tile_grid_neighbor_generator_top_macros.svh
// ----------------------------------------------------------------------------
// tile grid neighbor generator assertion macros
// concurrent check wrappers on i_clk with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef TILE_GRID_NEIGHBOR_GENERATOR_TOP_MACROS_SVH
`define TILE_GRID_NEIGHBOR_GENERATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define TGNG_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define TGNG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TGNG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TGNG_ASSERT_ALWAYS(label, expr, msg)
`define TGNG_ASSERT_SAME(label, ante, cons, msg)
`define TGNG_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/tgng_pkg.sv
// ----------------------------------------------------------------------------
// tgng_pkg
// shared types, register codes and neighbor offset tables
// ----------------------------------------------------------------------------
package tgng_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_ORIENTATION   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCLUDE_DIAGONALS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGGER_PARITY    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGGER_AXIS      = 3'd3;

    localparam logic [1:0] ORIENT_ORTHO = 2'd0;
    localparam logic [1:0] ORIENT_ISO   = 2'd1;
    localparam logic [1:0] ORIENT_STAG  = 2'd2;
    localparam logic [1:0] ORIENT_HEX   = 2'd3;

    typedef logic [2:0] t_pat;
    typedef logic [2:0] t_slot;

    localparam t_pat PAT_ORTHO      = 3'd0;
    localparam t_pat PAT_ISO        = 3'd1;
    localparam t_pat PAT_STAG_EVEN  = 3'd2;
    localparam t_pat PAT_STAG_ODD   = 3'd3;
    localparam t_pat PAT_HEXR_MATCH = 3'd4;
    localparam t_pat PAT_HEXR_OTHER = 3'd5;
    localparam t_pat PAT_HEXC_MATCH = 3'd6;
    localparam t_pat PAT_HEXC_OTHER = 3'd7;

    localparam t_slot SLOT_FIRST    = 3'd0;
    localparam t_slot SLOT_LAST_4   = 3'd3;
    localparam t_slot SLOT_LAST_6   = 3'd5;
    localparam t_slot SLOT_LAST_8   = 3'd7;

    typedef struct packed {
        t_pat  pat;
        t_slot last_slot;
    } t_cls;

    typedef logic signed [1:0] t_dx;
    typedef logic signed [2:0] t_dy;

    localparam t_dx XM1 = -2'sd1;
    localparam t_dx X0  = 2'sd0;
    localparam t_dx XP1 = 2'sd1;

    localparam t_dy YM2 = -3'sd2;
    localparam t_dy YM1 = -3'sd1;
    localparam t_dy Y0  = 3'sd0;
    localparam t_dy YP1 = 3'sd1;
    localparam t_dy YP2 = 3'sd2;

    localparam t_dx PAT_DX [8][8] = '{
        '{X0,  X0,  XM1, XP1, XP1, XP1, XM1, XM1},
        '{XM1, X0,  XP1, X0,  XM1, XP1, XP1, XM1},
        '{XM1, X0,  X0,  XM1, X0,  XP1, X0,  XM1},
        '{X0,  XP1, XP1, X0,  X0,  XP1, X0,  XM1},
        '{XM1, X0,  XP1, X0,  XM1, XM1, X0,  X0 },
        '{X0,  XP1, XP1, XP1, X0,  XM1, X0,  X0 },
        '{XM1, X0,  XP1, XP1, X0,  XM1, X0,  X0 },
        '{XM1, X0,  XP1, XP1, X0,  XM1, X0,  X0 }
    };

    localparam t_dy PAT_DY [8][8] = '{
        '{YM1, YP1, Y0,  Y0,  YM1, YP1, YP1, YM1},
        '{Y0,  YM1, Y0,  YP1, YM1, YM1, YP1, YP1},
        '{YM1, YM1, YP1, YP1, YM2, Y0,  YP2, Y0 },
        '{YM1, YM1, YP1, YP1, YM2, Y0,  YP2, Y0 },
        '{YM1, YM1, Y0,  YP1, YP1, Y0,  Y0,  Y0 },
        '{YM1, YM1, Y0,  YP1, YP1, Y0,  Y0,  Y0 },
        '{YM1, YM1, YM1, Y0,  YP1, Y0,  Y0,  Y0 },
        '{Y0,  YM1, Y0,  YP1, YP1, YP1, Y0,  Y0 }
    };

endpackage

FILE: design/tgng_front.sv
// ----------------------------------------------------------------------------
// tgng_front
// holds the map registers and classifies each tile into pattern and count
// ----------------------------------------------------------------------------
module tgng_front #(
    parameter int COORD_BITS = tgng_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tgng_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [tgng_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [COORD_BITS-1:0]           i_tile_x,
    input  logic signed [COORD_BITS-1:0]           i_tile_y,
    input  logic                                   i_q_full,
    output logic                                   o_push,
    output tgng_pkg::t_cls                         o_cls
);
    import tgng_pkg::*;

    logic [1:0] r_orient;
    logic       r_diag;
    logic       r_parity;
    logic       r_axis;
    logic       hex_par;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= ORIENT_ORTHO;
            r_diag   <= 1'b0;
            r_parity <= 1'b0;
            r_axis   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MAP_ORIENTATION:   r_orient <= i_cfg_data;
                REG_INCLUDE_DIAGONALS: r_diag   <= i_cfg_data[0];
                REG_STAGGER_PARITY:    r_parity <= i_cfg_data[0];
                REG_STAGGER_AXIS:      r_axis   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign hex_par    = r_axis ? i_tile_y[0] : i_tile_x[0];
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        unique case (r_orient)
            ORIENT_ORTHO: o_cls.pat = PAT_ORTHO;
            ORIENT_ISO:   o_cls.pat = PAT_ISO;
            ORIENT_STAG:  o_cls.pat = i_tile_y[0] ? PAT_STAG_ODD : PAT_STAG_EVEN;
            default: begin
                if (r_axis) begin
                    o_cls.pat = (hex_par == r_parity) ? PAT_HEXR_MATCH : PAT_HEXR_OTHER;
                end else begin
                    o_cls.pat = (hex_par == r_parity) ? PAT_HEXC_MATCH : PAT_HEXC_OTHER;
                end
            end
        endcase
        if (r_orient == ORIENT_HEX) begin
            o_cls.last_slot = SLOT_LAST_6;
        end else begin
            o_cls.last_slot = r_diag ? SLOT_LAST_8 : SLOT_LAST_4;
        end
    end

endmodule

FILE: design/tgng_queue.sv
// ----------------------------------------------------------------------------
// tgng_queue
// two-entry queue of classified tiles between front and back
// ----------------------------------------------------------------------------
`include "tile_grid_neighbor_generator_top_macros.svh"

module tgng_queue #(
    parameter int COORD_BITS = tgng_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  tgng_pkg::t_cls               i_cls,
    output logic                         o_full,
    output logic                         o_nempty,
    input  logic                         i_pop,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output tgng_pkg::t_cls               o_cls
);
    import tgng_pkg::*;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic signed [COORD_BITS-1:0] r_x   [2];
    logic signed [COORD_BITS-1:0] r_y   [2];
    t_cls                         r_cls [2];
    logic                         r_wr;
    logic                         r_rd;
    logic [1:0]                   r_cnt;
    logic [1:0]                   n_cnt;

    assign o_full   = (r_cnt == CNT_FULL);
    assign o_nempty = (r_cnt != CNT_EMPTY);
    assign o_x      = r_x[r_rd];
    assign o_y      = r_y[r_rd];
    assign o_cls    = r_cls[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= CNT_EMPTY;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_x[r_wr]   <= i_x;
            r_y[r_wr]   <= i_y;
            r_cls[r_wr] <= i_cls;
        end
    end

    `TGNG_ASSERT_ALWAYS(a_cnt_range, r_cnt <= CNT_FULL, "queue count out of range")
    `TGNG_ASSERT_SAME(a_pop_nempty, i_pop, r_cnt != CNT_EMPTY, "pop from empty queue")
    `TGNG_ASSERT_SAME(a_push_room, i_push && !i_pop, r_cnt != CNT_FULL, "push into full queue")

endmodule

FILE: design/tgng_back.sv
// ----------------------------------------------------------------------------
// tgng_back
// walks the offset table of one tile and drives the neighbor output register
// ----------------------------------------------------------------------------
`include "tile_grid_neighbor_generator_top_macros.svh"

module tgng_back #(
    parameter int COORD_BITS = tgng_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_nempty,
    input  logic signed [COORD_BITS-1:0] i_q_x,
    input  logic signed [COORD_BITS-1:0] i_q_y,
    input  tgng_pkg::t_cls               i_q_cls,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS:0]   o_neighbor_x,
    output logic signed [COORD_BITS:0]   o_neighbor_y,
    output logic [2:0]                   o_neighbor_slot,
    output logic                         o_last_neighbor
);
    import tgng_pkg::*;

    logic                         r_busy;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    t_cls                         r_cls;
    t_slot                        r_slot;
    logic                         r_out_valid;
    logic signed [COORD_BITS:0]   r_nx;
    logic signed [COORD_BITS:0]   r_ny;
    t_slot                        r_out_slot;
    logic                         r_out_last;

    logic                         out_load;
    logic                         gen;
    logic                         gen_last;
    t_dx                          dx;
    t_dy                          dy;
    logic signed [COORD_BITS:0]   n_nx;
    logic signed [COORD_BITS:0]   n_ny;

    assign out_load = !r_out_valid || !i_out_stall;
    assign gen      = r_busy && out_load;
    assign gen_last = (r_slot == r_cls.last_slot);
    assign o_pop    = i_q_nempty && (!r_busy || (gen && gen_last));

    assign dx   = PAT_DX[r_cls.pat][r_slot];
    assign dy   = PAT_DY[r_cls.pat][r_slot];
    assign n_nx = {r_x[COORD_BITS-1], r_x} + {{(COORD_BITS-1){dx[1]}}, dx};
    assign n_ny = {r_y[COORD_BITS-1], r_y} + {{(COORD_BITS-2){dy[2]}}, dy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= SLOT_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_slot <= SLOT_FIRST;
            end else if (gen) begin
                r_slot <= r_slot + 3'd1;
                if (gen_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x   <= i_q_x;
            r_y   <= i_q_y;
            r_cls <= i_q_cls;
        end
        if (gen) begin
            r_nx       <= n_nx;
            r_ny       <= n_ny;
            r_out_slot <= r_slot;
            r_out_last <= gen_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_neighbor_x    = r_nx;
    assign o_neighbor_y    = r_ny;
    assign o_neighbor_slot = r_out_slot;
    assign o_last_neighbor = r_out_last;

    `TGNG_ASSERT_SAME(a_last_slot, r_out_valid && r_out_last, r_out_slot == SLOT_LAST_4 || r_out_slot == SLOT_LAST_6 || r_out_slot == SLOT_LAST_8, "last word on a bad slot")
    `TGNG_ASSERT_NEXT(a_slot_step, r_out_valid && !i_out_stall && !r_out_last, r_out_valid && r_out_slot == ($past(r_out_slot) + 3'd1), "neighbor words not contiguous")
    `TGNG_ASSERT_NEXT(a_slot_restart, r_out_valid && !i_out_stall && r_out_last, !r_out_valid || r_out_slot == SLOT_FIRST, "new tile does not start at first slot")
    `TGNG_ASSERT_SAME(a_slot_bound, r_busy, r_slot <= r_cls.last_slot, "slot counter past tile count")

endmodule

FILE: design/tile_grid_neighbor_generator_top.sv
// ----------------------------------------------------------------------------
// tile_grid_neighbor_generator_top
// emits the neighbor coordinates of each tile for square, iso, staggered
// and hex maps
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
// tile      in         i_in_valid / o_in_stall   i_tile_x, i_tile_y
// neighbor  out        o_out_valid / i_out_stall o_neighbor_x, o_neighbor_y,
//                                                o_neighbor_slot, o_last_neighbor
//
// a tile yields 4, 6 or 8 neighbor words, one word per cycle from the back
// sequencer while the output is not stalled
// a tile passes the queue entry, the back tile registers, then the output register
// tiles are taken every cycle while the two-entry queue has room
// reset is synchronous; it empties the queue and sets the map registers
// an output stall holds the word and backs up into the queue, then the input
// ----------------------------------------------------------------------------
module tile_grid_neighbor_generator_top #(
    parameter int COORD_BITS = tgng_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tgng_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [tgng_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_BITS-1:0]        i_tile_x,
    input  logic signed [COORD_BITS-1:0]        i_tile_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [COORD_BITS:0]          o_neighbor_x,
    output logic signed [COORD_BITS:0]          o_neighbor_y,
    output logic [2:0]                          o_neighbor_slot,
    output logic                                o_last_neighbor
);
    import tgng_pkg::*;

    logic                         push;
    logic                         pop;
    logic                         q_full;
    logic                         q_nempty;
    t_cls                         f_cls;
    t_cls                         q_cls;
    logic signed [COORD_BITS-1:0] q_x;
    logic signed [COORD_BITS-1:0] q_y;

    tgng_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_tile_x    (i_tile_x),
        .i_tile_y    (i_tile_y),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cls       (f_cls)
    );

    tgng_queue #(
        .COORD_BITS (COORD_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_x      (i_tile_x),
        .i_y      (i_tile_y),
        .i_cls    (f_cls),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .i_pop    (pop),
        .o_x      (q_x),
        .o_y      (q_y),
        .o_cls    (q_cls)
    );

    tgng_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_nempty      (q_nempty),
        .i_q_x           (q_x),
        .i_q_y           (q_y),
        .i_q_cls         (q_cls),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_neighbor_x    (o_neighbor_x),
        .o_neighbor_y    (o_neighbor_y),
        .o_neighbor_slot (o_neighbor_slot),
        .o_last_neighbor (o_last_neighbor)
    );

endmodule
